FILE: rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    // Input commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Register indexes
    localparam int REG_MAX_MODE = 0;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_RD,
        ST_POP_WR,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DN_SWAP,
        ST_DN_WR,
        ST_TOP_RD,
        ST_RESULT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;      // capture input item into the working entry
        logic wr_new;       // write working entry at the current slot
        logic rd_parent;    // read parent of current position
        logic swap_up;      // write parent into cur, move position to parent
        logic rd_last;      // read last entry, drop count
        logic wr_root;      // write last entry to root
        logic rd_left;      // read left child
        logic rd_right;     // read right child
        logic pick_child;   // capture the winning child and its slot
        logic swap_dn;      // move best child up into the current slot
        logic wr_hole;      // park the working entry at the current slot
        logic rd_top;       // read root
        logic load_result;  // capture the result registers
        logic set_error;    // mark the result as refused
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_full;
        logic is_zero;
        logic at_root;      // current position is the root
        logic parent_loses; // working entry orders before parent
        logic has_left;
        logic has_right;
        logic child_wins;   // best child orders before working entry
    } stat_t;

endpackage

FILE: rtl/binary_heap_priority_queue.sv
// Binary heap priority queue: each push or pop gives one result holding the
// root entry, count and flags. The heap memory has a single port, one access
// per cycle, and a result that waits on the output holds off the next input.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Top level: APB register, controller and datapath.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic signed [KEY_BITS-1:0] key,
    input  logic [INDEX_BITS-1:0]      row_index,
    input  logic [INDEX_BITS-1:0]      col_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [KEY_BITS-1:0] top_key,
    output logic [INDEX_BITS-1:0]      top_row,
    output logic [INDEX_BITS-1:0]      top_col,
    output logic [6:0]                 entry_count,
    output logic                       is_empty,
    output logic                       op_error
);
    import bhpq_pkg::*;

    logic  max_mode_reg;
    ctrl_t ctrl;
    stat_t stat;

    // Mode register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'(REG_MAX_MODE * 4))
            max_mode_reg <= pwdata[0];
    end
    assign prdata = (paddr == 2'(REG_MAX_MODE * 4)) ? {31'b0, max_mode_reg} : '0;

    bhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (command),
        .in_ready (in_ready),
        .res_free (!out_valid || out_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bhpq_dpath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_mode  (max_mode_reg),
        .in_key    (key),
        .in_row    (row_index),
        .in_col    (col_index),
        .ctrl      (ctrl),
        .stat      (stat),
        .res_take  (out_ready),
        .res_valid (out_valid),
        .res_key   (top_key),
        .res_row   (top_row),
        .res_col   (top_col),
        .res_count (entry_count),
        .res_empty (is_empty),
        .res_error (op_error)
    );
endmodule

FILE: rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/bhpq_ctrl.sv
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for push sift-up and pop sift-down.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  logic              res_free,
    input  bhpq_pkg::stat_t   stat,
    output bhpq_pkg::ctrl_t   ctrl
);
    import bhpq_pkg::*;

    state_t state_reg, state_next;
    logic   right_wait_reg, right_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            right_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            right_wait_reg <= right_wait_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next      = state_reg;
        right_wait_next = right_wait_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_PUSH)
                        state_next = stat.is_full ? ST_TOP_RD : ST_PUSH_WR;
                    else
                        state_next = stat.is_zero ? ST_TOP_RD : ST_POP_RD;
                end
            end
            ST_PUSH_WR: state_next = stat.at_root ? ST_TOP_RD : ST_UP_RD;
            ST_UP_RD:   state_next = ST_UP_CMP;
            ST_UP_CMP:
            begin
                if (stat.parent_loses)
                    state_next = ST_PUSH_WR;
                else
                    state_next = ST_TOP_RD;
            end
            ST_POP_RD:  state_next = ST_POP_WR;
            ST_POP_WR:  state_next = ST_DN_RD;
            ST_DN_RD:
            begin
                if (!stat.has_left)
                    state_next = ST_DN_WR;
                else
                begin
                    state_next      = ST_DN_CMP;
                    right_wait_next = stat.has_right;
                end
            end
            ST_DN_CMP:
            begin
                if (right_wait_reg)
                    right_wait_next = 1'b0;
                else
                    state_next = stat.child_wins ? ST_DN_SWAP : ST_DN_WR;
            end
            ST_DN_SWAP: state_next = ST_DN_RD;
            ST_DN_WR:   state_next = ST_TOP_RD;
            ST_TOP_RD:  state_next = ST_RESULT;
            ST_RESULT:  if (res_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load_in = in_valid;
                ctrl.set_error = in_valid &&
                    ((in_cmd == CMD_PUSH) ? stat.is_full : stat.is_zero);
            end
            ST_PUSH_WR: ctrl.wr_new = 1'b1;
            ST_UP_RD:   ctrl.rd_parent = 1'b1;
            ST_UP_CMP:  ctrl.swap_up = stat.parent_loses;
            ST_POP_RD:  ctrl.rd_last = 1'b1;
            ST_POP_WR:  ctrl.wr_root = 1'b1;
            ST_DN_RD:   ctrl.rd_left = stat.has_left;
            ST_DN_CMP:
            begin
                ctrl.rd_right   = right_wait_reg;
                ctrl.pick_child = !right_wait_reg && stat.child_wins;
            end
            ST_DN_SWAP: ctrl.swap_dn = 1'b1;
            ST_DN_WR:   ctrl.wr_hole = 1'b1;
            ST_TOP_RD:  ctrl.rd_top = 1'b1;
            ST_RESULT:  ctrl.load_result = res_free;
            default:    ctrl = '0;
        endcase
    end
endmodule

FILE: rtl/bhpq_dpath.sv
// ----------------------------------------------------------------------------
// bhpq_dpath
// Heap memory, position and count registers, key compare and result regs.
// ----------------------------------------------------------------------------
module bhpq_dpath #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         max_mode,
    input  logic signed [KEY_BITS-1:0]   in_key,
    input  logic [INDEX_BITS-1:0]        in_row,
    input  logic [INDEX_BITS-1:0]        in_col,
    input  bhpq_pkg::ctrl_t              ctrl,
    output bhpq_pkg::stat_t              stat,
    input  logic                         res_take,
    output logic                         res_valid,
    output logic signed [KEY_BITS-1:0]   res_key,
    output logic [INDEX_BITS-1:0]        res_row,
    output logic [INDEX_BITS-1:0]        res_col,
    output logic [6:0]                   res_count,
    output logic                         res_empty,
    output logic                         res_error
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + 2 * INDEX_BITS;

    // Current slot holds 2*pos+2 up to 2*CAPACITY, so one extra bit
    logic [CW:0]    pos_reg, pos_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [EW-1:0]  ent_reg, ent_next;   // entry that sifts
    logic [EW-1:0]  best_reg, best_next; // left child, then winning child
    logic [CW:0]    bpos_reg, bpos_next;
    logic           err_reg, err_next;
    logic           right_seen_reg, right_seen_next;

    logic           we;
    logic [AW-1:0]  addr;
    logic [EW-1:0]  wdata, rdata;

    bhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Key order: a before b
    function automatic logic before_f(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                      input logic mx);
        logic signed [KEY_BITS-1:0] ka, kb;
        ka = a[EW-1 -: KEY_BITS];
        kb = b[EW-1 -: KEY_BITS];
        return mx ? (ka > kb) : (ka < kb);
    endfunction

    logic [CW:0]   parent_pos, left_pos, right_pos, cand_pos;
    logic [EW-1:0] cand_ent;
    logic          right_takes;
    assign parent_pos = (pos_reg - 1'b1) >> 1;
    assign left_pos   = {pos_reg[CW-1:0], 1'b1};
    assign right_pos  = left_pos + 1'b1;

    // Child pick: right only when strictly ahead of left
    assign right_takes = right_seen_reg && before_f(rdata, best_reg, max_mode);
    assign cand_ent    = (right_seen_reg && !right_takes) ? best_reg : rdata;
    assign cand_pos    = right_takes ? right_pos : left_pos;

    assign stat.is_full      = (cnt_reg == CW'(CAPACITY));
    assign stat.is_zero      = (cnt_reg == '0);
    assign stat.at_root      = (pos_reg == '0);
    assign stat.parent_loses = before_f(ent_reg, rdata, max_mode);
    assign stat.has_left     = (left_pos < {1'b0, cnt_reg});
    assign stat.has_right    = (right_pos < {1'b0, cnt_reg});
    assign stat.child_wins   = before_f(cand_ent, ent_reg, max_mode);

    // Memory port
    always_comb
    begin
        we    = 1'b0;
        addr  = '0;
        wdata = ent_reg;
        priority if (ctrl.wr_new)
        begin
            we   = 1'b1;
            addr = pos_reg[AW-1:0];
        end
        else if (ctrl.rd_parent)
            addr = parent_pos[AW-1:0];
        else if (ctrl.swap_up)
        begin
            we    = 1'b1;
            addr  = pos_reg[AW-1:0];
            wdata = rdata;
        end
        else if (ctrl.rd_last)
            addr = AW'(cnt_reg - 1'b1);
        else if (ctrl.wr_root)
        begin
            we    = 1'b1;
            wdata = rdata;
        end
        else if (ctrl.rd_left)
            addr = left_pos[AW-1:0];
        else if (ctrl.rd_right)
            addr = right_pos[AW-1:0];
        else if (ctrl.swap_dn)
        begin
            we    = 1'b1;
            addr  = pos_reg[AW-1:0];
            wdata = best_reg;
        end
        else if (ctrl.wr_hole)
        begin
            we   = 1'b1;
            addr = pos_reg[AW-1:0];
        end
        else if (ctrl.rd_top)
            addr = '0;
    end

    // Working registers
    always_comb
    begin
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        ent_next        = ent_reg;
        best_next       = best_reg;
        bpos_next       = bpos_reg;
        err_next        = err_reg;
        right_seen_next = right_seen_reg;
        if (ctrl.load_in)
        begin
            ent_next = {in_key, in_row, in_col};
            pos_next = {1'b0, cnt_reg};
            err_next = ctrl.set_error;
        end
        if (ctrl.wr_new && pos_reg == {1'b0, cnt_reg})
            cnt_next = cnt_reg + 1'b1;
        if (ctrl.swap_up)
            pos_next = parent_pos;
        if (ctrl.rd_last)
            cnt_next = cnt_reg - 1'b1;
        if (ctrl.wr_root)
        begin
            ent_next = rdata;
            pos_next = '0;
        end
        if (ctrl.rd_left)
            right_seen_next = 1'b0;
        if (ctrl.rd_right)
        begin
            // left data arrives now
            best_next       = rdata;
            right_seen_next = 1'b1;
        end
        if (ctrl.pick_child)
        begin
            best_next = cand_ent;
            bpos_next = cand_pos;
        end
        if (ctrl.swap_dn)
            pos_next = bpos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            bpos_reg       <= '0;
            right_seen_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            bpos_reg       <= bpos_next;
            right_seen_reg <= right_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        best_reg <= best_next;
    end

    // Result register
    logic [EW-1:0] top_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid <= 1'b0;
        else if (ctrl.load_result)
            res_valid <= 1'b1;
        else if (res_take)
            res_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            top_reg   <= stat.is_zero ? '0 : rdata;
            res_count <= 7'(cnt_reg);
            res_empty <= stat.is_zero;
            res_error <= err_reg;
        end
    end

    assign res_key = top_reg[EW-1 -: KEY_BITS];
    assign res_row = top_reg[2*INDEX_BITS-1 -: INDEX_BITS];
    assign res_col = top_reg[INDEX_BITS-1:0];

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(CAPACITY))
        else $error("count over capacity");
    // A refused item leaves the count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.set_error |=> $stable(cnt_reg))
        else $error("refused item changed count");
    // Result only loaded when the output side is free
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_result |-> !res_valid || res_take)
        else $error("result overwritten");
endmodule
